>>> hdl/ssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants of the spatial stereo gain unit.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int IN_W      = 288;
  localparam int OUT_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DIST_RECIP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_VOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_VOL   = 2'd2;

  localparam logic [31:0] DIST_RECIP_RST = 32'd65536;
  localparam logic [15:0] EMIT_VOL_RST   = 16'd4096;
  localparam logic [15:0] CHAN_VOL_RST   = 16'd4096;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 48;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_MAG,
    OP_SQ,
    OP_SUM,
    OP_RT,
    OP_KD,
    OP_Q,
    OP_ATT,
    OP_CVEV,
    OP_M1,
    OP_M2,
    OP_DIV,
    OP_UST,
    OP_DOT,
    OP_GL,
    OP_GR,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
  } stat_t;

endpackage

>>> hdl/spatial_stereo_gain_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_stereo_gain_unit
// Stereo pan gains with distance attenuation, one result word per input word.
//
//   channel  dir  width  contents
//   in_      in   288    emitter xyz, listener xyz (Q16.16), ear dirs (Q2.14)
//   out_     out  64     left start/end, right start/end gains (Q4.12)
//   cfg_     in   32     distance_reciprocal, emitter_volume, channel_volume
//
// The result register is written in the final step; the next word is taken
// the cycle after. The four 48-step divisions and two 32-step square roots
// of the shared iterative units take most of the time per word.
// Synchronous active-low reset; no clearing pass.
// A result waiting on out_tready holds the unit in its final step only.
// ----------------------------------------------------------------------------
module spatial_stereo_gain_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // emitter_x, emitter_y, emitter_z, listener_x, listener_y, listener_z,
  // left_ear_x, left_ear_y, left_ear_z, right_ear_x, right_ear_y, right_ear_z
  input  logic [ssg_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // left_gain_start, left_gain_end, right_gain_start, right_gain_end
  output logic [ssg_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_we,
  input  logic [ssg_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ssg_pkg::CFG_W-1:0]     cfg_wdata
);
  import ssg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ssg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ssg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_word  (out_tdata)
  );

  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!stat.sqrt_busy && !stat.div_busy))
    else $error("input taken while an iterative unit is busy");

  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> (in_tvalid && in_tready))
    else $error("load without an accepted word");

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!out_tvalid || out_tready))
    else $error("result written over a pending word");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.op == OP_OUT))
    else $error("result valid without a write");

endmodule

>>> hdl/ssg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_dp
// Datapath: config registers, shared multiplier, iterative square root and
// divider, dot products, gain rounding and the result register.
// ----------------------------------------------------------------------------
module ssg_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssg_pkg::cmd_t                cmd,
  output ssg_pkg::stat_t               stat,
  input  logic [ssg_pkg::IN_W-1:0]     in_word,
  input  logic                         cfg_we,
  input  logic [ssg_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ssg_pkg::CFG_W-1:0]    cfg_wdata,
  output logic [ssg_pkg::OUT_W-1:0]    out_word
);
  import ssg_pkg::*;

  localparam int SQ_CNT_W = $clog2(SQRT_STEPS);
  localparam int DV_CNT_W = $clog2(DIV_STEPS);

  logic [31:0]        dist_recip_r;
  logic [15:0]        emit_vol_r, chan_vol_r, prev_l_r, prev_r_r;
  logic signed [32:0] diff_r [3];
  logic signed [15:0] ear_l_r [3];
  logic signed [15:0] ear_r_r [3];
  logic [32:0]        abs_v [3];
  logic               shift_v;
  logic [31:0]        mag_r [3];
  logic [2:0]         neg_r;
  logic               shift_r;
  logic [63:0]        acc_r, prod_r;
  logic [31:0]        mul_a, mul_b;
  logic [31:0]        r_r;
  logic               d_hi_r, far_r;
  logic [32:0]        d_v;
  logic [12:0]        att_r;
  logic [21:0]        m_r;
  logic [63:0]        msum;
  logic signed [15:0] u_r [3];
  logic signed [31:0] pl_v, pr_v;
  logic signed [33:0] dot_l_r, dot_r_r;
  logic signed [34:0] pan_l, pan_r;
  logic [31:0]        pan_l_pos, pan_r_pos;
  logic [63:0]        gsum;
  logic [15:0]        sat_v, gl_r;
  logic [OUT_W-1:0]   out_word_r;
  logic [15:0]        qv;
  logic [16:0]        qden, qnum;
  logic [30:0]        att_num;
  logic [14:0]        cdiv;
  logic [15:0]        cu;

  // square root unit
  logic [63:0]          sq_x_r;
  logic [34:0]          sq_rem_r, sq_rem_n, sq_trial;
  logic [31:0]          sq_root_r;
  logic                 sq_ge, sq_busy_r, sq_start;
  logic [SQ_CNT_W-1:0]  sq_cnt_r;

  // divider unit
  logic [47:0]          dv_n_r;
  logic [31:0]          dv_rem_r, dv_den_r;
  logic [32:0]          dv_rem_n;
  logic                 dv_ge, dv_busy_r, dv_start;
  logic [DV_CNT_W-1:0]  dv_cnt_r;

  assign stat     = {sq_busy_r, dv_busy_r};
  assign out_word = out_word_r;

  always_comb begin
    shift_v = 1'b0;
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = diff_r[i][32] ? 33'(-diff_r[i]) : 33'(diff_r[i]);
      shift_v  = shift_v | abs_v[i][32] | abs_v[i][31];
    end
  end

  assign d_v = shift_r ? {sq_root_r, 1'b0} : {1'b0, sq_root_r};

  always_comb begin
    case (cmd.op)
      OP_SQ: begin
        mul_a = mag_r[cmd.idx];
        mul_b = mag_r[cmd.idx];
      end
      OP_KD: begin
        mul_a = dist_recip_r;
        mul_b = d_v[31:0];
      end
      OP_CVEV: begin
        mul_a = {16'b0, chan_vol_r};
        mul_b = {16'b0, emit_vol_r};
      end
      OP_M1: begin
        mul_a = prod_r[31:0];
        mul_b = {19'b0, att_r};
      end
      OP_GL: begin
        mul_a = pan_l_pos;
        mul_b = {10'b0, m_r};
      end
      OP_GR: begin
        mul_a = pan_r_pos;
        mul_b = {10'b0, m_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign msum      = prod_r + 64'd8388608;
  assign pan_l     = 35'sh10000000 + {dot_l_r[33], dot_l_r};
  assign pan_r     = 35'sh10000000 + {dot_r_r[33], dot_r_r};
  assign pan_l_pos = (!pan_l[34] && (pan_l != '0)) ? pan_l[31:0] : '0;
  assign pan_r_pos = (!pan_r[34] && (pan_r != '0)) ? pan_r[31:0] : '0;
  assign gsum      = prod_r + 64'd268435456;
  assign sat_v     = (gsum[63:45] != '0) ? 16'hFFFF : gsum[44:29];
  assign pl_v      = u_r[cmd.idx] * ear_l_r[cmd.idx];
  assign pr_v      = u_r[cmd.idx] * ear_r_r[cmd.idx];

  assign qv      = sq_root_r[15:0];
  assign qden    = 17'h10000 + {1'b0, qv};
  assign qnum    = 17'h10000 - {1'b0, qv};
  assign att_num = {1'b0, qnum, 13'b0} + {14'b0, qden};
  assign cdiv    = dv_n_r[14:0];
  assign cu      = {1'b0, cdiv};

  assign sq_start = (cmd.op == OP_RT) || (cmd.op == OP_Q);
  assign dv_start = (cmd.op == OP_ATT) || (cmd.op == OP_DIV);
  assign sq_rem_n = {sq_rem_r[32:0], sq_x_r[63:62]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign sq_ge    = sq_rem_n >= sq_trial;
  assign dv_rem_n = {dv_rem_r, dv_n_r[47]};
  assign dv_ge    = dv_rem_n >= {1'b0, dv_den_r};

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_recip_r <= DIST_RECIP_RST;
      emit_vol_r   <= EMIT_VOL_RST;
      chan_vol_r   <= CHAN_VOL_RST;
      prev_l_r     <= EMIT_VOL_RST;
      prev_r_r     <= EMIT_VOL_RST;
      sq_busy_r    <= 1'b0;
      sq_cnt_r     <= '0;
      dv_busy_r    <= 1'b0;
      dv_cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_DIST_RECIP: dist_recip_r <= cfg_wdata;
          REG_EMIT_VOL: begin
            emit_vol_r <= cfg_wdata[15:0];
            prev_l_r   <= cfg_wdata[15:0];
            prev_r_r   <= cfg_wdata[15:0];
          end
          REG_CHAN_VOL: chan_vol_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_OUT) begin
        prev_l_r <= gl_r;
        prev_r_r <= sat_v;
      end
      if (sq_start) begin
        sq_busy_r <= 1'b1;
        sq_cnt_r  <= SQ_CNT_W'(SQRT_STEPS - 1);
      end else if (sq_busy_r) begin
        if (sq_cnt_r == '0) sq_busy_r <= 1'b0;
        else sq_cnt_r <= sq_cnt_r - 1'b1;
      end
      if (dv_start) begin
        dv_busy_r <= 1'b1;
        dv_cnt_r  <= DV_CNT_W'(DIV_STEPS - 1);
      end else if (dv_busy_r) begin
        if (dv_cnt_r == '0) dv_busy_r <= 1'b0;
        else dv_cnt_r <= dv_cnt_r - 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          diff_r[i]  <= $signed({in_word[32*i+31], in_word[32*i +: 32]})
                      - $signed({in_word[96+32*i+31], in_word[96+32*i +: 32]});
          ear_l_r[i] <= in_word[192+16*i +: 16];
          ear_r_r[i] <= in_word[240+16*i +: 16];
        end
        dot_l_r <= '0;
        dot_r_r <= '0;
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= shift_v ? abs_v[i][32:1] : abs_v[i][31:0];
          neg_r[i] <= diff_r[i][32];
        end
        shift_r <= shift_v;
      end
      OP_SQ: begin
        acc_r  <= (cmd.idx == 2'd0) ? '0 : acc_r + prod_r;
        prod_r <= mul_a * mul_b;
      end
      OP_SUM: acc_r <= acc_r + prod_r;
      OP_KD: begin
        r_r    <= sq_root_r;
        d_hi_r <= d_v[32];
        prod_r <= mul_a * mul_b;
      end
      OP_Q: far_r <= ((dist_recip_r != '0) && d_hi_r) || (prod_r[63:32] != '0);
      OP_CVEV: begin
        att_r  <= far_r ? '0 : dv_n_r[12:0];
        prod_r <= mul_a * mul_b;
      end
      OP_M1: prod_r <= mul_a * mul_b;
      OP_M2: m_r <= msum[45:24];
      OP_UST: begin
        if (r_r == '0) u_r[cmd.idx] <= (cmd.idx == 2'd2) ? 16'sd16384 : 16'sd0;
        else u_r[cmd.idx] <= neg_r[cmd.idx] ? -cu : cu;
      end
      OP_DOT: begin
        dot_l_r <= dot_l_r + 34'(pl_v);
        dot_r_r <= dot_r_r + 34'(pr_v);
      end
      OP_GL: prod_r <= mul_a * mul_b;
      OP_GR: begin
        gl_r   <= sat_v;
        prod_r <= mul_a * mul_b;
      end
      OP_OUT: out_word_r <= {sat_v, prev_r_r, gl_r, prev_l_r};
      default: ;
    endcase

    // square root, one result bit from two radicand bits per step
    if (cmd.op == OP_RT) begin
      sq_x_r    <= acc_r;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (cmd.op == OP_Q) begin
      sq_x_r    <= {32'b0, prod_r[31:0]};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (sq_busy_r) begin
      sq_x_r    <= {sq_x_r[61:0], 2'b00};
      sq_rem_r  <= sq_ge ? sq_rem_n - sq_trial : sq_rem_n;
      sq_root_r <= {sq_root_r[30:0], sq_ge};
    end

    // restoring divider, one quotient bit per step
    if (cmd.op == OP_ATT) begin
      dv_n_r   <= {17'b0, att_num};
      dv_den_r <= {14'b0, qden, 1'b0};
      dv_rem_r <= '0;
    end else if (cmd.op == OP_DIV) begin
      dv_n_r   <= {2'b0, mag_r[cmd.idx], 14'b0};
      dv_den_r <= r_r;
      dv_rem_r <= '0;
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_ge ? 32'(dv_rem_n - {1'b0, dv_den_r}) : dv_rem_n[31:0];
      dv_n_r   <= {dv_n_r[46:0], dv_ge};
    end
  end

endmodule

>>> hdl/ssg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_ctrl
// Sequencer: steps the datapath through one word and holds the result valid.
// ----------------------------------------------------------------------------
module ssg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  ssg_pkg::stat_t stat,
  output ssg_pkg::cmd_t  cmd
);
  import ssg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MAG, S_SQ, S_SUM, S_RT, S_RT_W, S_KD, S_Q, S_Q_W, S_ATT, S_ATT_W,
    S_CVEV, S_M1, S_M2, S_DIV, S_DIV_W, S_UST, S_DOT, S_GL, S_GR, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign slot_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd.op         = OP_NOP;
    cmd.idx        = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        idx_nxt   = 2'd0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op  = OP_SQ;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_RT;
      end
      S_RT: begin
        cmd.op    = OP_RT;
        state_nxt = S_RT_W;
      end
      S_RT_W: if (!stat.sqrt_busy) state_nxt = S_KD;
      S_KD: begin
        cmd.op    = OP_KD;
        state_nxt = S_Q;
      end
      S_Q: begin
        cmd.op    = OP_Q;
        state_nxt = S_Q_W;
      end
      S_Q_W: if (!stat.sqrt_busy) state_nxt = S_ATT;
      S_ATT: begin
        cmd.op    = OP_ATT;
        state_nxt = S_ATT_W;
      end
      S_ATT_W: if (!stat.div_busy) state_nxt = S_CVEV;
      S_CVEV: begin
        cmd.op    = OP_CVEV;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = OP_M2;
        idx_nxt   = 2'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op    = OP_DIV;
        state_nxt = S_DIV_W;
      end
      S_DIV_W: if (!stat.div_busy) state_nxt = S_UST;
      S_UST: begin
        cmd.op = OP_UST;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = S_DOT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_DIV;
        end
      end
      S_DOT: begin
        cmd.op  = OP_DOT;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) state_nxt = S_GL;
      end
      S_GL: begin
        cmd.op    = OP_GL;
        state_nxt = S_GR;
      end
      S_GR: begin
        cmd.op    = OP_GR;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.op         = OP_OUT;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule
